/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smm assertion failed");

// next-cycle implication, disabled while in reset
`define SMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smm assertion failed");

`endif

/* hw/rtl/smm_pkg.sv */
// shared types and constants of the sparse matrix multiply block
// no dependencies; imported by smm_cfg and sparse_matrix_multiply
package smm_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int VAL_W   = 32;
  localparam int SIZE_W  = 5;
  localparam int ENTRY_W = VAL_W + 1;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_LOAD_A  = 2'd1,
    MODE_LOAD_B  = 2'd2,
    MODE_COMPUTE = 2'd3
  } mode_t;

  // apb register map, one 32-bit word per register
  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROWS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FILL_A   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILL_B   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FILL_OUT = 3'd5;

  typedef struct packed {
    logic [SIZE_W-1:0]       rows_of_a;
    logic [SIZE_W-1:0]       inner_size;
    logic [SIZE_W-1:0]       cols_of_b;
    logic signed [VAL_W-1:0] fill_a;
    logic signed [VAL_W-1:0] fill_b;
    logic signed [VAL_W-1:0] fill_out;
  } cfg_t;

endpackage

/* hw/rtl/smm_ram.sv */
// generic single-write, single-read synchronous ram with registered read
// no dependencies; used for the matrix stores
module smm_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/smm_cfg.sv */
// apb configuration registers of the sparse matrix multiply block
// depends on smm_pkg for the register map and the cfg_t bundle
module smm_cfg
  import smm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_ROWS:     cfg_nxt.rows_of_a  = pwdata[SIZE_W-1:0];
        REG_INNER:    cfg_nxt.inner_size = pwdata[SIZE_W-1:0];
        REG_COLS:     cfg_nxt.cols_of_b  = pwdata[SIZE_W-1:0];
        REG_FILL_A:   cfg_nxt.fill_a     = pwdata;
        REG_FILL_B:   cfg_nxt.fill_b     = pwdata;
        REG_FILL_OUT: cfg_nxt.fill_out   = pwdata;
        default:      cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROWS:     prdata = {{(32-SIZE_W){1'b0}}, cfg_r.rows_of_a};
      REG_INNER:    prdata = {{(32-SIZE_W){1'b0}}, cfg_r.inner_size};
      REG_COLS:     prdata = {{(32-SIZE_W){1'b0}}, cfg_r.cols_of_b};
      REG_FILL_A:   prdata = cfg_r.fill_a;
      REG_FILL_B:   prdata = cfg_r.fill_b;
      REG_FILL_OUT: prdata = cfg_r.fill_out;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_of_a  <= SIZE_W'(16);
      cfg_r.inner_size <= SIZE_W'(16);
      cfg_r.cols_of_b  <= SIZE_W'(16);
      cfg_r.fill_a     <= '0;
      cfg_r.fill_b     <= '0;
      cfg_r.fill_out   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/sparse_matrix_multiply.sv */
// Sparse integer matrix multiply, top level.
// Input channel (in_valid/in_ready) takes one item at a time: clear, load A,
// load B or compute row. Results leave on out_valid/out_ready, one product
// entry per item, in ascending column order, out_last on the final one; a
// row with nothing off the out fill value gives a single row_empty result.
// Configuration through the apb port (sizes and fill values), written idle.
// A load is written into its store. A clear sweeps all MAX_DIM*MAX_DIM
// addresses of both stores (256 at the default), and the same sweep runs after
// reset, during which no item is accepted while apb writes still go through.
// A compute row issues inner*cols products in turn (256 at the default sizes),
// one at a time through the single read port of each store and the one shared
// multiply-accumulate.
// Results are held one behind so the last flag is known; a stalled receiver
// holds the pipeline, nothing is dropped, and in_ready stays low until the
// final result of the row has been loaded into the output register.
// Reset is synchronous, active low.
// depends on smm_pkg, smm_cfg, smm_ram and assert_macros.svh
`include "assert_macros.svh"

module sparse_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic [ROW_W-1:0]        in_row_index,
  input  logic [COL_W-1:0]        in_col_index,
  input  logic signed [VAL_W-1:0] in_element_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_row_empty,
  output logic                    out_last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_AW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPUTE,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             first;
    logic             last_inner;
    logic [IDX_W-1:0] col;
  } tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (CW'(v) > CW'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  cfg_t cfg;

  smm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // control registers
  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic             s2_v_r, s2_v_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic [ROW_W-1:0] row_r;
  logic [IDX_W-1:0] row0_r;
  tag_t             s1_tag_r;
  tag_t             s2_tag_r;
  logic [VAL_W-1:0] prod_r;
  logic [VAL_W-1:0] acc_r;
  logic [IDX_W-1:0] pend_col_r;
  logic [VAL_W-1:0] pend_val_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_empty_r;
  logic             out_last_r;

  // store ports
  logic               a_we, b_we, ram_re;
  logic [AW-1:0]      w_addr, a_raddr, b_raddr;
  logic [ENTRY_W-1:0] w_data, a_rdata, b_rdata;

  smm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (w_addr),
    .wdata (w_data),
    .re    (ram_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (w_addr),
    .wdata (w_data),
    .re    (ram_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mode_t            in_mode_e;
  logic [DIM_W-1:0] nrows, ninner, ncols;
  logic [IDX_W-1:0] n_last, p_last;
  logic             row_ok, load_ok;
  logic [AW-1:0]    load_addr;
  logic [VAL_W-1:0] a_op, b_op, prod;
  logic [VAL_W-1:0] sum;
  logic             hit, out_free, stall, adv, issue, push, fin_load, load_out;

  assign in_mode_e = mode_t'(in_mode);
  assign nrows     = clamp_dim(cfg.rows_of_a);
  assign ninner    = clamp_dim(cfg.inner_size);
  assign ncols     = clamp_dim(cfg.cols_of_b);
  assign n_last    = IDX_W'(ninner - DIM_W'(1));
  assign p_last    = IDX_W'(ncols - DIM_W'(1));

  assign row_ok  = (in_row_index != '0) && (CW'(in_row_index) <= CW'(nrows));
  assign load_ok = (in_row_index != '0) && (CW'(in_row_index) <= CW'(MAX_DIM)) &&
                   (in_col_index != '0) && (CW'(in_col_index) <= CW'(MAX_DIM));
  assign load_addr = AW'(AW'(in_row_index - ROW_W'(1)) * AW'(MAX_DIM)) +
                     AW'(in_col_index - COL_W'(1));

  // row of a walks along n, column of b walks down n
  assign a_raddr = AW'(AW'(row0_r) * AW'(MAX_DIM)) + AW'(n_r);
  assign b_raddr = AW'(AW'(n_r) * AW'(MAX_DIM)) + AW'(p_r);

  assign in_ready = (state_r == ST_IDLE);
  assign issue    = (state_r == ST_COMPUTE);

  // stage 1: entries not present read as fill, then one multiply
  assign a_op = a_rdata[VAL_W] ? a_rdata[VAL_W-1:0] : cfg.fill_a;
  assign b_op = b_rdata[VAL_W] ? b_rdata[VAL_W-1:0] : cfg.fill_b;
  assign prod = a_op * b_op;

  // stage 2: accumulate and test the finished column
  assign sum      = (s2_tag_r.first ? '0 : acc_r) + prod_r;
  assign hit      = s2_v_r && s2_tag_r.last_inner && (sum != cfg.fill_out);
  assign out_free = !out_valid_r || out_ready;
  assign stall    = hit && pend_v_r && !out_free;
  assign adv      = !stall;
  assign push     = hit && pend_v_r && out_free;
  assign fin_load = (state_r == ST_FIN) && out_free;
  assign load_out = push || fin_load;
  assign ram_re   = issue && adv;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    pend_v_nxt    = pend_v_r;
    a_we          = 1'b0;
    b_we          = 1'b0;
    w_addr        = clr_addr_r;
    w_data        = '0;
    s1_v_nxt      = adv ? issue : s1_v_r;
    s2_v_nxt      = adv ? s1_v_r : s2_v_r;
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    unique case (state_r)
      ST_CLEAR: begin
        a_we = 1'b1;
        b_we = 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode_e)
            MODE_CLEAR: begin
              state_nxt    = ST_CLEAR;
              clr_addr_nxt = '0;
            end
            MODE_LOAD_A: begin
              a_we   = load_ok;
              w_addr = load_addr;
              w_data = {1'b1, in_element_value};
            end
            MODE_LOAD_B: begin
              b_we   = load_ok;
              w_addr = load_addr;
              w_data = {1'b1, in_element_value};
            end
            MODE_COMPUTE: begin
              n_nxt     = '0;
              p_nxt     = '0;
              state_nxt = row_ok ? ST_COMPUTE : ST_FIN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_COMPUTE: begin
        if (adv) begin
          if (n_r == n_last) begin
            n_nxt = '0;
            if (p_r == p_last) begin
              state_nxt = ST_DRAIN;
            end else begin
              p_nxt = p_r + IDX_W'(1);
            end
          end else begin
            n_nxt = n_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (adv && hit) begin
      pend_v_nxt = 1'b1;
    end
    if (fin_load) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      n_r         <= '0;
      p_r         <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      n_r         <= n_nxt;
      p_r         <= p_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid && (in_mode_e == MODE_COMPUTE)) begin
      row_r  <= in_row_index;
      row0_r <= IDX_W'(in_row_index - ROW_W'(1));
    end
    if (adv) begin
      s1_tag_r.first      <= (n_r == '0);
      s1_tag_r.last_inner <= (n_r == n_last);
      s1_tag_r.col        <= p_r;
      s2_tag_r            <= s1_tag_r;
      prod_r              <= prod;
      if (s2_v_r) begin
        acc_r <= sum;
      end
      if (hit) begin
        pend_col_r <= s2_tag_r.col;
        pend_val_r <= sum;
      end
    end
    if (push) begin
      out_row_r   <= row_r;
      out_col_r   <= COL_W'(pend_col_r) + COL_W'(1);
      out_value_r <= pend_val_r;
      out_empty_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (fin_load) begin
      out_row_r   <= row_r;
      out_col_r   <= pend_v_r ? COL_W'(pend_col_r) + COL_W'(1) : '0;
      out_value_r <= pend_v_r ? pend_val_r : '0;
      out_empty_r <= !pend_v_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_row_empty = out_empty_r;
  assign out_last      = out_last_r;

  // an idle block has an empty pipeline and nothing held back
  `SMM_ASSERT_IMP(a_idle_empty, clk, rst_n, in_ready, !s1_v_r && !s2_v_r && !pend_v_r)
  // the output register is only overwritten once its item is gone
  `SMM_ASSERT_IMP(a_load_free, clk, rst_n, load_out, !out_valid_r || out_ready)
  // the closing item is formed only after the last column is through
  `SMM_ASSERT_IMP(a_fin_drained, clk, rst_n, fin_load, !s1_v_r && !s2_v_r)
  // a stall freezes the accumulator and keeps the stage-2 item
  `SMM_ASSERT_NXT(a_stall_holds, clk, rst_n, stall, $stable(acc_r) && s2_v_r)

endmodule
